// ===== rtl/core/apdsc_pkg.sv =====
// shared types and constants for the aspect preserving dimension scaler
// no dependencies; used by every module of the block by scoped names
package apdsc_pkg;

    // side length width
    localparam int DIM_BITS = 14;
    // divisor width: twice the source side
    localparam int DEN_W = DIM_BITS + 1;
    // rounded dividend 2*a*b + c
    localparam int NUM_W = 2 * DIM_BITS + 2;
    // product width
    localparam int PROD_W = 2 * DIM_BITS;
    // packed beat widths, whole bytes
    localparam int IN_W  = ((5 * DIM_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((2 * DIM_BITS + 7) / 8) * 8;
    localparam int USER_W = 2;

    typedef logic [DIM_BITS-1:0] dim_t;

    // per-item side information carried along the divider chain
    typedef struct packed {
        logic scale_en;   // one side is scaled
        logic scale_w;    // the scaled side is the width
        logic ovf;        // quotient does not fit, saturate
        logic err;        // divisor of the scaled side was zero
        logic fmt_valid;  // request matches an allowed case
        dim_t fix_w;      // width when not scaled
        dim_t fix_h;      // height when not scaled
    } info_t;

    // contents of one divider cell
    typedef struct packed {
        logic [DEN_W-1:0] rem;  // partial remainder, always below dsr
        logic [DEN_W-1:0] dsr;  // divisor 2*c
        dim_t             dvd;  // dividend bits still to shift in
        dim_t             quo;  // quotient bits so far
        info_t            info;
    } cell_t;

endpackage

// ===== rtl/core/apdsc_front.sv =====
// front end: case decode, product a*b, then dividend setup and overflow check
// depends on apdsc_pkg
module apdsc_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [apdsc_pkg::IN_W-1:0] in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output apdsc_pkg::cell_t         out_data
);

    localparam int D = apdsc_pkg::DIM_BITS;

    apdsc_pkg::dim_t rw, rh, sw, sh, mn;
    apdsc_pkg::dim_t op_a, op_b, op_c;
    apdsc_pkg::info_t dec_info;

    logic                          s1_valid_reg, s1_valid_next;
    apdsc_pkg::info_t              s1_info_reg;
    logic [apdsc_pkg::PROD_W-1:0]  s1_prod_reg;
    apdsc_pkg::dim_t               s1_c_reg;
    logic                          s1_ready;

    logic                          s2_valid_reg, s2_valid_next;
    apdsc_pkg::cell_t              s2_data_reg;
    logic                          s2_ready;

    logic [apdsc_pkg::NUM_W-1:0]   num;
    logic [apdsc_pkg::DEN_W-1:0]   den;
    logic [apdsc_pkg::NUM_W-1:0]   den_top;
    logic                          ovf;
    apdsc_pkg::cell_t              s2_data_next;

    // field unpack
    assign rw = in_data[0*D +: D];
    assign rh = in_data[1*D +: D];
    assign sw = in_data[2*D +: D];
    assign sh = in_data[3*D +: D];
    assign mn = in_data[4*D +: D];

    // case table: pick the scaled side and its operands a*b/c
    always_comb begin
        dec_info          = '0;
        dec_info.scale_en = 1'b1;
        dec_info.scale_w  = 1'b0;
        dec_info.fix_w    = rw;
        dec_info.fix_h    = rh;
        op_a = sh;
        op_b = rw;
        op_c = sw;
        if (rw == '0 && rh == '0) begin
            if (mn != '0) begin
                if (sw > sh) begin
                    dec_info.scale_w = 1'b1;
                    dec_info.fix_h   = mn;
                    op_a = sw;
                    op_b = mn;
                    op_c = sh;
                end else begin
                    dec_info.fix_w = mn;
                    op_a = sh;
                    op_b = mn;
                    op_c = sw;
                end
            end else begin
                dec_info.scale_en = 1'b0;
                dec_info.fix_w    = sw;
                dec_info.fix_h    = sh;
            end
        end else if (rh == '0) begin
            dec_info.fix_w = rw;
        end else if (rw == '0) begin
            dec_info.scale_w = 1'b1;
            dec_info.fix_h   = rh;
            op_a = sw;
            op_b = rh;
            op_c = sh;
        end else begin
            dec_info.scale_en = 1'b0;
        end
        dec_info.err       = dec_info.scale_en && (op_c == '0);
        dec_info.fmt_valid = (rw == '0 && rh == '0) || (mn == '0);
    end

    // stage handshakes
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // stage 1: multiply, zero divisor replaced by one to keep the chain sane
    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_info_reg <= dec_info;
            s1_prod_reg <= op_a * op_b;
            s1_c_reg    <= (op_c == '0) ? apdsc_pkg::dim_t'(1) : op_c;
        end
    end

    // stage 2: dividend 2ab+c, divisor 2c, overflow when quotient needs more bits
    assign num     = {1'b0, s1_prod_reg, 1'b0} + apdsc_pkg::NUM_W'(s1_c_reg);
    assign den     = {s1_c_reg, 1'b0};
    assign den_top = apdsc_pkg::NUM_W'({den, {D{1'b0}}});
    assign ovf     = (num >= den_top);

    always_comb begin
        s2_data_next          = '0;
        s2_data_next.info     = s1_info_reg;
        s2_data_next.info.ovf = ovf;
        s2_data_next.dsr      = den;
        s2_data_next.rem      = ovf ? '0 : num[D +: apdsc_pkg::DEN_W];
        s2_data_next.dvd      = num[D-1:0];
        s2_data_next.quo      = '0;
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

// ===== rtl/core/apdsc_cell.sv =====
// one restoring division cell: shifts in one dividend bit, yields one quotient bit
// depends on apdsc_pkg
module apdsc_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  apdsc_pkg::cell_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output apdsc_pkg::cell_t out_data
);

    localparam int D = apdsc_pkg::DIM_BITS;
    localparam int W = apdsc_pkg::DEN_W;

    logic             valid_reg, valid_next;
    apdsc_pkg::cell_t data_reg, data_next;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             qbit;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // trial subtract of the divisor from the shifted remainder
    assign trial = {in_data.rem, in_data.dvd[D-1]};
    assign diff  = trial - {1'b0, in_data.dsr};
    assign qbit  = (trial >= {1'b0, in_data.dsr});

    always_comb begin
        data_next     = in_data;
        data_next.rem = qbit ? diff[W-1:0] : trial[W-1:0];
        data_next.dvd = {in_data.dvd[D-2:0], 1'b0};
        data_next.quo = {in_data.quo[D-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef ASSERT_OFF
    // remainder stays below the divisor
    a_rem_below_dsr: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg.rem < data_reg.dsr))
        else $error("cell remainder not below divisor");

    // divisor is never zero inside the chain
    a_dsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg.dsr != '0))
        else $error("cell divisor is zero");

    // a zero divisor is only flagged for a scaled side
    a_err_scaled: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && data_reg.info.err) |-> data_reg.info.scale_en)
        else $error("divide error without a scaled side");

    // a held beat is not lost while downstream stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("cell dropped a stalled beat");
`endif

endmodule

// ===== rtl/core/aspect_preserving_dimension_scaler_unit.sv =====
// top level of the aspect preserving dimension scaler: front end, divider chain,
// result register; depends on apdsc_pkg, apdsc_front and apdsc_cell
//
// Each input beat carries a requested size, a source size and a minimum side;
// the result beat carries the output width and height (each at least 1,
// saturated to the field range), a format valid flag and a divide error flag.
// The block takes one beat per clock when the output is not stalled; each result
// passes through the case decode and multiply register, the dividend setup
// register, one register for each of the 14 division cells (one quotient bit
// per cell), and the result register. Results leave in the order the requests
// arrived; backpressure stalls stages only where they are full, so bubbles are
// squeezed out.
module aspect_preserving_dimension_scaler_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // req_width, req_height, src_width, src_height, min_side, zero fill
    input  logic [apdsc_pkg::IN_W-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // dest_width, dest_height, zero fill
    output logic [apdsc_pkg::OUT_W-1:0]   m_tdata,
    // format_valid, div_error
    output logic [apdsc_pkg::USER_W-1:0]  m_tuser
);

    localparam int D = apdsc_pkg::DIM_BITS;

    logic             lnk_valid [D+1];
    logic             lnk_ready [D+1];
    apdsc_pkg::cell_t lnk_data  [D+1];

    logic             out_ready;
    logic             m_valid_reg, m_valid_next;
    apdsc_pkg::dim_t  m_width_reg, m_height_reg;
    logic             m_fmt_reg, m_err_reg;
    apdsc_pkg::dim_t  q_side, width_next, height_next;
    apdsc_pkg::info_t last_info;

    // decode and dividend setup
    apdsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (lnk_valid[0]),
        .out_ready (lnk_ready[0]),
        .out_data  (lnk_data[0])
    );

    // division cells, most significant quotient bit first
    for (genvar i = 0; i < D; i++) begin : g_cell
        apdsc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lnk_valid[i]),
            .in_ready  (lnk_ready[i]),
            .in_data   (lnk_data[i]),
            .out_valid (lnk_valid[i+1]),
            .out_ready (lnk_ready[i+1]),
            .out_data  (lnk_data[i+1])
        );
    end

    // result assembly: saturate, force one on divide error, clamp zero to one
    assign last_info = lnk_data[D].info;
    assign q_side = last_info.err ? apdsc_pkg::dim_t'(1) :
                    last_info.ovf ? '1 : lnk_data[D].quo;

    always_comb begin
        width_next  = last_info.fix_w;
        height_next = last_info.fix_h;
        if (last_info.scale_en) begin
            if (last_info.scale_w) begin
                width_next = q_side;
            end else begin
                height_next = q_side;
            end
        end
        if (width_next == '0) begin
            width_next = apdsc_pkg::dim_t'(1);
        end
        if (height_next == '0) begin
            height_next = apdsc_pkg::dim_t'(1);
        end
    end

    // output register
    assign out_ready    = !m_valid_reg || m_tready;
    assign lnk_ready[D] = out_ready;
    assign m_valid_next = out_ready ? lnk_valid[D] : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && lnk_valid[D]) begin
            m_width_reg  <= width_next;
            m_height_reg <= height_next;
            m_fmt_reg    <= last_info.fmt_valid;
            m_err_reg    <= last_info.err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = apdsc_pkg::OUT_W'({m_height_reg, m_width_reg});
    assign m_tuser  = {m_err_reg, m_fmt_reg};

endmodule

// ===== verif/aspect_preserving_dimension_scaler_unit_tb.sv =====
// self-checking testbench for the aspect preserving dimension scaler unit
// depends on apdsc_pkg and aspect_preserving_dimension_scaler_unit; directed, random
// and backpressure beats are checked against a built-in size predictor
module aspect_preserving_dimension_scaler_unit_tb;

    localparam int DW = apdsc_pkg::DIM_BITS;
    localparam int FILL_W = apdsc_pkg::IN_W - 5 * DW;

    typedef apdsc_pkg::dim_t dim_t;

    // one request beat
    typedef struct packed {
        dim_t req_width;
        dim_t req_height;
        dim_t src_width;
        dim_t src_height;
        dim_t min_side;
    } size_req_t;

    // one result beat
    typedef struct packed {
        dim_t dest_width;
        dim_t dest_height;
        logic format_valid;
        logic div_error;
    } dims_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // req_width, req_height, src_width, src_height, min_side, zero fill
    logic [apdsc_pkg::IN_W-1:0]    s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // dest_width, dest_height, zero fill
    logic [apdsc_pkg::OUT_W-1:0]   m_tdata;
    // format_valid, div_error
    logic [apdsc_pkg::USER_W-1:0]  m_tuser;

    dims_t expected_dims[$];
    int    mismatch_count = 0;
    bit    tx_idle_en = 1'b1;
    bit    rx_idle_en = 1'b1;
    int    hold_cycles = 0;

    aspect_preserving_dimension_scaler_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // round-half-up of a*b/c, c nonzero
    function automatic logic [63:0] round_quotient(input logic [63:0] a, input logic [63:0] b,
                                                   input logic [63:0] c);
        return (2 * a * b + c) / (2 * c);
    endfunction

    // force a side into 1 .. max
    function automatic dim_t clamp_dim(input logic [63:0] v);
        if (v < 1)
            return dim_t'(1);
        if (v > {DW{1'b1}})
            return '1;
        return dim_t'(v);
    endfunction

    // expected output size and flags for one request
    function automatic dims_t predict_dims(input size_req_t r);
        logic [63:0] rw, rh, sw, sh, mn, w, h;
        logic        err;
        dims_t       d;
        rw = r.req_width;
        rh = r.req_height;
        sw = r.src_width;
        sh = r.src_height;
        mn = r.min_side;
        err = 1'b0;
        if (rw == 0 && rh == 0) begin
            if (mn != 0) begin
                // shorter side takes the minimum, landscape only when strictly wider
                if (sw > sh) begin
                    h = mn;
                    if (sh == 0) begin
                        err = 1'b1;
                        w = 1;
                    end else begin
                        w = round_quotient(sw, mn, sh);
                    end
                end else begin
                    w = mn;
                    if (sw == 0) begin
                        err = 1'b1;
                        h = 1;
                    end else begin
                        h = round_quotient(sh, mn, sw);
                    end
                end
            end else begin
                w = sw;
                h = sh;
            end
        end else if (rh == 0) begin
            w = rw;
            if (sw == 0) begin
                err = 1'b1;
                h = 1;
            end else begin
                h = round_quotient(sh, rw, sw);
            end
        end else if (rw == 0) begin
            h = rh;
            if (sh == 0) begin
                err = 1'b1;
                w = 1;
            end else begin
                w = round_quotient(sw, rh, sh);
            end
        end else begin
            w = rw;
            h = rh;
        end
        d.dest_width   = clamp_dim(w);
        d.dest_height  = clamp_dim(h);
        d.format_valid = (rw == 0 && rh == 0) || (mn == 0);
        d.div_error    = err;
        return d;
    endfunction

    function automatic size_req_t make_req(input int rw, input int rh, input int sw,
                                           input int sh, input int mn);
        size_req_t r;
        r.req_width  = dim_t'(rw);
        r.req_height = dim_t'(rh);
        r.src_width  = dim_t'(sw);
        r.src_height = dim_t'(sh);
        r.min_side   = dim_t'(mn);
        return r;
    endfunction

    // side value biased toward edges and small sizes
    function automatic dim_t rand_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return dim_t'(1);
            2: return '1;
            3, 4: return dim_t'($urandom_range(1, 64));
            5, 6: return dim_t'($urandom_range(1, 4096));
            default: return dim_t'($urandom());
        endcase
    endfunction

    function automatic dim_t rand_nonzero_dim();
        dim_t v;
        v = rand_dim();
        if (v == 0)
            v = dim_t'($urandom_range(1, {DW{1'b1}}));
        return v;
    endfunction

    // request mostly shaped after one of the five cases
    function automatic size_req_t rand_request();
        size_req_t r;
        r.src_width  = rand_dim();
        r.src_height = rand_dim();
        r.req_width  = '0;
        r.req_height = '0;
        r.min_side   = '0;
        case ($urandom_range(0, 9))
            0: ;
            1, 2: r.min_side = rand_nonzero_dim();
            3, 4: begin
                r.req_width = rand_nonzero_dim();
                if ($urandom_range(0, 7) == 0)
                    r.min_side = rand_dim();
            end
            5, 6: begin
                r.req_height = rand_nonzero_dim();
                if ($urandom_range(0, 7) == 0)
                    r.min_side = rand_dim();
            end
            7: begin
                r.req_width  = rand_nonzero_dim();
                r.req_height = rand_nonzero_dim();
                if ($urandom_range(0, 3) == 0)
                    r.min_side = rand_dim();
            end
            default: begin
                r.req_width  = dim_t'($urandom());
                r.req_height = dim_t'($urandom());
                r.min_side   = dim_t'($urandom());
            end
        endcase
        return r;
    endfunction

    // offer one request beat, record its expected result once taken
    task automatic send_request(input size_req_t r);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tdata  <= {{FILL_W{1'b0}}, r.min_side, r.src_height, r.src_width,
                     r.req_height, r.req_width};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_dims.push_back(predict_dims(r));
    endtask

    // receiver: random stall bursts, plus long hold-offs on request
    initial begin
        forever begin
            if (hold_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        dims_t exp_d;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_dims.size() == 0) begin
                $error("result beat with no request pending: tdata=%h tuser=%b",
                       m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                exp_d = expected_dims.pop_front();
                if (m_tdata[DW-1:0] !== exp_d.dest_width) begin
                    $error("dest_width expected %0d actual %0d",
                           exp_d.dest_width, m_tdata[DW-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[2*DW-1:DW] !== exp_d.dest_height) begin
                    $error("dest_height expected %0d actual %0d",
                           exp_d.dest_height, m_tdata[2*DW-1:DW]);
                    mismatch_count++;
                end
                if (m_tuser[0] !== exp_d.format_valid) begin
                    $error("format_valid expected %0b actual %0b",
                           exp_d.format_valid, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[1] !== exp_d.div_error) begin
                    $error("div_error expected %0b actual %0b",
                           exp_d.div_error, m_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    // corner cases of every branch
    task automatic test_directed();
        // keep source size, including zero and max sources
        send_request(make_req(0, 0, 0, 0, 0));
        send_request(make_req(0, 0, 16383, 16383, 0));
        send_request(make_req(0, 0, 640, 480, 0));
        // minimum side: landscape, portrait, square tie goes to width
        send_request(make_req(0, 0, 1920, 1080, 720));
        send_request(make_req(0, 0, 1080, 1920, 720));
        send_request(make_req(0, 0, 500, 500, 16383));
        // minimum side with zero divisor on either branch
        send_request(make_req(0, 0, 100, 0, 64));
        send_request(make_req(0, 0, 0, 0, 64));
        send_request(make_req(0, 0, 0, 77, 1));
        // minimum side saturating
        send_request(make_req(0, 0, 16383, 1, 16383));
        // width only: normal, zero divisor, zero result, saturation
        send_request(make_req(1280, 0, 1920, 1080, 0));
        send_request(make_req(1280, 0, 0, 1080, 0));
        send_request(make_req(1, 0, 16383, 1, 0));
        send_request(make_req(16383, 0, 1, 16383, 0));
        // height only: normal, zero divisor, half rounds up, saturation
        send_request(make_req(0, 720, 1920, 1080, 0));
        send_request(make_req(0, 720, 1920, 0, 0));
        send_request(make_req(0, 1, 3, 2, 0));
        send_request(make_req(0, 16383, 16383, 1, 0));
        // both given, then given sizes with minimum set, which is not an allowed case
        send_request(make_req(16383, 16383, 16383, 16383, 0));
        send_request(make_req(1, 1, 0, 0, 5));
        send_request(make_req(1280, 0, 1920, 1080, 720));
        send_request(make_req(0, 720, 1920, 1080, 16383));
        send_request(make_req(16383, 16383, 16383, 16383, 16383));
    endtask

    task automatic test_random();
        repeat (420) send_request(rand_request());
    endtask

    // long receiver hold-off while requests keep coming, fills the pipeline
    task automatic test_full_stall();
        tx_idle_en = 1'b0;
        hold_cycles = 120;
        repeat (40) send_request(rand_request());
    endtask

    // back-to-back beats with no idling on either side
    task automatic test_streaming();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (40) send_request(rand_request());
        s_tvalid <= 1'b0;
    endtask

    initial begin
        test_reset();
        test_directed();
        test_random();
        test_full_stall();
        test_streaming();
        while (expected_dims.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
